// ----- sv/bmst_pkg.sv -----
// Shared constants and types for the Boruvka spanning-tree weight block.
package bmst_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned MAX_EDGES = 4096;

  localparam int unsigned NODE_W  = $clog2(MAX_NODES);     // vertex index
  localparam int unsigned ID_W    = 11;                    // vertex id field
  localparam int unsigned EADDR_W = $clog2(MAX_EDGES);     // edge store index
  localparam int unsigned ETOT_W  = EADDR_W + 1;           // edge count
  localparam int unsigned WGT_W   = 32;
  localparam int unsigned SUM_W   = 42;
  localparam int unsigned RANK_W  = 4;
  localparam int unsigned EDGE_W  = 2 * ID_W + WGT_W;
  localparam int unsigned CHO_W   = 1 + EADDR_W + WGT_W;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RCHK,
    S_CLR,
    S_SCAN,
    S_ERD,
    S_FIND_RD,
    S_FIND_WT,
    S_OFF_RD,
    S_OFF_WT,
    S_MSEL,
    S_MCH_WT,
    S_RK_A,
    S_RK_B,
    S_JOIN,
    S_DONE
  } state_e;

endpackage

// ----- sv/bmst_ram.sv -----
// Single-port synchronous RAM with registered read data.
module bmst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- sv/bmst_ctrl.sv -----
// Sequencer for edge loading, Boruvka rounds and the union-find memories.
module bmst_ctrl
  import bmst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ID_W-1:0]   node_count_i,
  input  logic              start,
  output logic              busy,
  input  logic [ID_W-1:0]   edge_from_i,
  input  logic [ID_W-1:0]   edge_to_i,
  input  logic [WGT_W-1:0]  edge_weight_i,
  input  logic              last_edge_i,
  output logic              done_o,
  output logic [SUM_W-1:0]  tree_weight_o,
  output logic              connected_o,
  output logic              edge_overflow_o
);

  state_e state_q, state_d;

  logic [ID_W-1:0]    idx_q, idx_d, n_q, n_d, trees_q, trees_d;
  logic [ID_W-1:0]    ea_q, ea_d, eb_q, eb_d;
  logic [ETOT_W-1:0]  e_q, e_d, etot_q, etot_d;
  logic [WGT_W-1:0]   ew_q, ew_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [NODE_W-1:0]  x_q, x_d, ra_q, ra_d, rb_q, rb_d;
  logic [RANK_W-1:0]  rka_q, rka_d;
  logic               ovf_q, ovf_d, merged_q, merged_d;
  logic               phase_q, phase_d, fsel_q, fsel_d, osel_q, osel_d;

  // Memory ports
  logic               e_we, p_we, r_we, c_we;
  logic [EADDR_W-1:0] e_addr;
  logic [NODE_W-1:0]  p_addr, r_addr, c_addr;
  logic [EDGE_W-1:0]  e_wdata, e_rdata;
  logic [NODE_W-1:0]  p_wdata, p_rdata;
  logic [RANK_W-1:0]  r_wdata, r_rdata;
  logic [CHO_W-1:0]   c_wdata, c_rdata;

  logic               accept, c_valid, in_range;
  logic [EADDR_W-1:0] c_idx;
  logic [WGT_W-1:0]   c_wgt;
  logic [SUM_W:0]     sum_add;
  logic [ID_W-1:0]    n_clamp;
  logic [ID_W-1:0]    rd_from, rd_to;

  bmst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge (
    .clk_i, .we_i(e_we), .addr_i(e_addr), .wdata_i(e_wdata), .rdata_o(e_rdata));
  bmst_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wdata), .rdata_o(p_rdata));
  bmst_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank (
    .clk_i, .we_i(r_we), .addr_i(r_addr), .wdata_i(r_wdata), .rdata_o(r_rdata));
  bmst_ram #(.WIDTH(CHO_W), .DEPTH(MAX_NODES)) u_choice (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata));

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign {c_valid, c_idx, c_wgt} = c_rdata;
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(ew_q);

  // Clamp the vertex count into the supported range
  always_comb begin
    if (node_count_i == '0) begin
      n_clamp = ID_W'(1);
    end else if (node_count_i > ID_W'(MAX_NODES)) begin
      n_clamp = ID_W'(MAX_NODES);
    end else begin
      n_clamp = node_count_i;
    end
  end

  // Endpoints of the edge coming out of the store
  assign rd_from  = e_rdata[EDGE_W-1 -: ID_W];
  assign rd_to    = e_rdata[WGT_W +: ID_W];
  assign in_range = (rd_from != '0) && (rd_from <= n_q) && (rd_to != '0) && (rd_to <= n_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (accept && last_edge_i) state_d = S_INIT;
      S_INIT:    if (idx_q == n_q - ID_W'(1)) state_d = S_RCHK;
      S_RCHK:    state_d = (trees_q > ID_W'(1)) ? S_CLR : S_DONE;
      S_CLR:     if (idx_q == n_q - ID_W'(1)) state_d = S_SCAN;
      S_SCAN:    state_d = (e_q == etot_q) ? S_MSEL : S_ERD;
      S_ERD: begin
        if (!phase_q && !in_range) state_d = S_SCAN;
        else state_d = S_FIND_RD;
      end
      S_FIND_RD: state_d = S_FIND_WT;
      S_FIND_WT: begin
        if (p_rdata != x_q || !fsel_q) state_d = S_FIND_RD;
        else if (ra_q == x_q) state_d = phase_q ? S_MSEL : S_SCAN;
        else state_d = phase_q ? S_RK_A : S_OFF_RD;
      end
      S_OFF_RD:  state_d = S_OFF_WT;
      S_OFF_WT:  state_d = osel_q ? S_SCAN : S_OFF_RD;
      S_MSEL: begin
        if (idx_q == n_q) state_d = merged_q ? S_RCHK : S_DONE;
        else state_d = S_MCH_WT;
      end
      S_MCH_WT:  state_d = c_valid ? S_ERD : S_MSEL;
      S_RK_A:    state_d = S_RK_B;
      S_RK_B:    state_d = S_JOIN;
      S_JOIN:    state_d = S_MSEL;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    idx_d = idx_q;   n_d = n_q;       trees_d = trees_q;
    ea_d = ea_q;     eb_d = eb_q;     ew_d = ew_q;
    e_d = e_q;       etot_d = etot_q; sum_d = sum_q;
    x_d = x_q;       ra_d = ra_q;     rb_d = rb_q;     rka_d = rka_q;
    ovf_d = ovf_q;   merged_d = merged_q;
    phase_d = phase_q; fsel_d = fsel_q; osel_d = osel_q;
    e_we = 1'b0; e_addr = etot_q[EADDR_W-1:0];
    e_wdata = {edge_from_i, edge_to_i, edge_weight_i};
    p_we = 1'b0; p_addr = x_q; p_wdata = idx_q[NODE_W-1:0];
    r_we = 1'b0; r_addr = ra_q; r_wdata = '0;
    c_we = 1'b0; c_addr = idx_q[NODE_W-1:0]; c_wdata = '0;
    unique case (state_q)
      // Store the edge beat, or flag it as dropped
      S_IDLE: begin
        if (accept) begin
          if (etot_q < ETOT_W'(MAX_EDGES)) begin
            e_we   = 1'b1;
            etot_d = etot_q + ETOT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_edge_i) begin
            n_d   = n_clamp;
            idx_d = '0;
          end
        end
      end
      // Make every vertex its own root
      S_INIT: begin
        p_we = 1'b1; p_addr = idx_q[NODE_W-1:0];
        r_we = 1'b1; r_addr = idx_q[NODE_W-1:0];
        idx_d = idx_q + ID_W'(1);
        trees_d = n_q;
        sum_d = '0;
      end
      S_RCHK: idx_d = '0;
      // Empty the per-root choices
      S_CLR: begin
        c_we = 1'b1;
        idx_d = idx_q + ID_W'(1);
        e_d = '0; merged_d = 1'b0; phase_d = 1'b0;
      end
      S_SCAN: begin
        e_addr = e_q[EADDR_W-1:0];
        phase_d = (e_q == etot_q);
        idx_d = '0;
      end
      // Latch the edge and start the first find
      S_ERD: begin
        {ea_d, eb_d, ew_d} = e_rdata;
        x_d = NODE_W'(rd_from - ID_W'(1));
        fsel_d = 1'b0;
        if (!phase_q && !in_range) e_d = e_q + ETOT_W'(1);
      end
      S_FIND_RD: p_addr = x_q;
      // Walk toward the root
      S_FIND_WT: begin
        if (p_rdata != x_q) begin
          x_d = p_rdata;
        end else if (!fsel_q) begin
          ra_d = x_q;
          x_d = NODE_W'(eb_q - ID_W'(1));
          fsel_d = 1'b1;
        end else begin
          rb_d = x_q;
          osel_d = 1'b0;
          if (ra_q == x_q) begin
            if (phase_q) idx_d = idx_q + ID_W'(1);
            else e_d = e_q + ETOT_W'(1);
          end
        end
      end
      S_OFF_RD: c_addr = osel_q ? rb_q : ra_q;
      // Keep the first lightest edge per root
      S_OFF_WT: begin
        c_addr = osel_q ? rb_q : ra_q;
        c_wdata = {1'b1, e_q[EADDR_W-1:0], ew_q};
        c_we = !c_valid || (c_wgt > ew_q);
        osel_d = 1'b1;
        if (osel_q) e_d = e_q + ETOT_W'(1);
      end
      S_MSEL: c_addr = idx_q[NODE_W-1:0];
      // Fetch the winning edge of this root
      S_MCH_WT: begin
        e_addr = c_idx;
        if (!c_valid) idx_d = idx_q + ID_W'(1);
      end
      S_RK_A: r_addr = ra_q;
      S_RK_B: begin
        r_addr = rb_q;
        rka_d = r_rdata;
      end
      // Union by rank and add the weight
      S_JOIN: begin
        if (rka_q < r_rdata) begin
          p_we = 1'b1; p_addr = ra_q; p_wdata = rb_q;
        end else begin
          p_we = 1'b1; p_addr = rb_q; p_wdata = ra_q;
          if (rka_q == r_rdata && rka_q != RANK_MAX) begin
            r_we = 1'b1; r_addr = ra_q; r_wdata = rka_q + RANK_W'(1);
          end
        end
        sum_d = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        trees_d = trees_q - ID_W'(1);
        merged_d = 1'b1;
        idx_d = idx_q + ID_W'(1);
      end
      // Release the store for the next graph
      S_DONE: begin
        etot_d = '0;
        ovf_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      etot_q  <= '0;
      ovf_q   <= 1'b0;
      sum_q   <= '0;
      trees_q <= ID_W'(1);
      n_q     <= ID_W'(1);
      idx_q   <= '0;
      e_q     <= '0;
      merged_q <= 1'b0;
      phase_q <= 1'b0;
      fsel_q  <= 1'b0;
      osel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      etot_q  <= etot_d;
      ovf_q   <= ovf_d;
      sum_q   <= sum_d;
      trees_q <= trees_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      e_q     <= e_d;
      merged_q <= merged_d;
      phase_q <= phase_d;
      fsel_q  <= fsel_d;
      osel_q  <= osel_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    ea_q  <= ea_d;
    eb_q  <= eb_d;
    ew_q  <= ew_d;
    x_q   <= x_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
    rka_q <= rka_d;
  end

  assign done_o          = (state_q == S_DONE);
  assign tree_weight_o   = sum_q;
  assign connected_o     = (trees_q == ID_W'(1));
  assign edge_overflow_o = ovf_q;

endmodule

// ----- sv/boruvka_mst_weight.sv -----
// An edge is stored when start is seen while idle; an edge with last_edge set starts the rounds.
// A run first makes every vertex its own root, then per round clears the choices,
// scans all stored edges (one edge read plus two root walks through the parent
// memory each) and makes a merge pass over the n roots; all of it is paced by the
// single-port parent and choice memories. The result strobe lasts one cycle.
// Reset empties the edge store count and sets node_count to 1; memories are not cleared.
module boruvka_mst_weight
  import bmst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [ID_W-1:0]   edge_from_i,
  input  logic [ID_W-1:0]   edge_to_i,
  input  logic [WGT_W-1:0]  edge_weight_i,
  input  logic              last_edge_i,
  output logic              done_o,
  output logic [SUM_W-1:0]  tree_weight_o,
  output logic              connected_o,
  output logic              edge_overflow_o
);

  logic [ID_W-1:0] node_count_q;

  // Write the node count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= ID_W'(1);
    end else if (psel && penable && pwrite && paddr == REG_NODE_COUNT) begin
      node_count_q <= pwdata[ID_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_NODE_COUNT) ? {{(32-ID_W){1'b0}}, node_count_q} : '0;

  bmst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .node_count_i(node_count_q),
    .start, .busy,
    .edge_from_i, .edge_to_i, .edge_weight_i, .last_edge_i,
    .done_o, .tree_weight_o, .connected_o, .edge_overflow_o
  );

endmodule

// ----- bench/bmst_checker.sv -----
// Checker for the Boruvka spanning-tree weight block: predicts each graph result and compares.
module bmst_checker
  import bmst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              start,
  input  logic              busy,
  input  logic [ID_W-1:0]   edge_from_i,
  input  logic [ID_W-1:0]   edge_to_i,
  input  logic [WGT_W-1:0]  edge_weight_i,
  input  logic              last_edge_i,
  input  logic              done_o,
  input  logic [SUM_W-1:0]  tree_weight_o,
  input  logic              connected_o,
  input  logic              edge_overflow_o,
  output int                fail_count_o,
  output int                awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0]  from_id;
    logic [ID_W-1:0]  to_id;
    logic [WGT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [SUM_W-1:0] tree_weight;
    logic             connected;
    logic             overflow;
  } span_t;

  edge_t               graph_edges [MAX_EDGES];
  int unsigned         graph_edge_cnt;
  logic                graph_ovf;
  logic [ID_W-1:0]     node_cnt;
  int unsigned         uf_parent [MAX_NODES];
  logic [RANK_W-1:0]   uf_rank [MAX_NODES];
  int unsigned         best_edge [MAX_NODES];
  bit                  best_valid [MAX_NODES];
  span_t               span_expect_q [$];
  int                  mismatches;

  // Root lookup with path compression.
  function automatic int unsigned uf_root(int unsigned v);
    int unsigned r;
    int unsigned nx;
    r = v;
    while (uf_parent[r] != r) r = uf_parent[r];
    while (uf_parent[v] != r) begin
      nx = uf_parent[v];
      uf_parent[v] = r;
      v = nx;
    end
    return r;
  endfunction

  // Keep the first lightest edge seen for a component.
  function automatic void offer_edge(int unsigned root, int unsigned e);
    if (!best_valid[root] || graph_edges[best_edge[root]].weight > graph_edges[e].weight) begin
      best_valid[root] = 1'b1;
      best_edge[root] = e;
    end
  endfunction

  // Run Boruvka rounds over the stored graph.
  function automatic span_t span_of_graph();
    int unsigned n;
    int unsigned trees;
    int unsigned a;
    int unsigned b;
    int unsigned ra;
    int unsigned rb;
    logic [SUM_W:0] acc;
    bit merged;
    span_t res;
    n = node_cnt;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    for (int unsigned i = 0; i < n; i++) begin
      uf_parent[i] = i;
      uf_rank[i] = '0;
    end
    trees = n;
    acc = '0;
    while (trees > 1) begin
      merged = 1'b0;
      for (int unsigned i = 0; i < n; i++) best_valid[i] = 1'b0;
      for (int unsigned e = 0; e < graph_edge_cnt; e++) begin
        a = graph_edges[e].from_id;
        b = graph_edges[e].to_id;
        if (a < 1 || a > n || b < 1 || b > n) continue;
        ra = uf_root(a - 1);
        rb = uf_root(b - 1);
        if (ra != rb) begin
          offer_edge(ra, e);
          offer_edge(rb, e);
        end
      end
      for (int unsigned i = 0; i < n; i++) begin
        if (!best_valid[i]) continue;
        ra = uf_root(graph_edges[best_edge[i]].from_id - 1);
        rb = uf_root(graph_edges[best_edge[i]].to_id - 1);
        if (ra != rb) begin
          acc = acc + graph_edges[best_edge[i]].weight;
          if (acc > {1'b0, SUM_MAX}) acc = {1'b0, SUM_MAX};
          if (uf_rank[ra] < uf_rank[rb]) uf_parent[ra] = rb;
          else if (uf_rank[ra] > uf_rank[rb]) uf_parent[rb] = ra;
          else begin
            uf_parent[rb] = ra;
            if (uf_rank[ra] < RANK_MAX) uf_rank[ra] = uf_rank[ra] + 1'b1;
          end
          trees--;
          merged = 1'b1;
        end
      end
      if (!merged) break;
    end
    res.tree_weight = acc[SUM_W-1:0];
    res.connected = (trees == 1);
    res.overflow = graph_ovf;
    return res;
  endfunction

  task automatic report_field(string fname, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t mismatch %s: expected %0d actual %0d", $realtime, fname, exp_v, act_v);
    end
  endtask

  // Track register writes, accepted edges and result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    span_t exp_s;
    if (!rst_ni) begin
      node_cnt <= 11'd1;
      graph_edge_cnt = 0;
      graph_ovf = 1'b0;
      span_expect_q.delete();
      awaiting_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_NODE_COUNT)
        node_cnt <= pwdata[ID_W-1:0];
      if (done_o) begin
        if (span_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%t unexpected result beat", $realtime);
        end else begin
          exp_s = span_expect_q.pop_front();
          report_field("tree_weight", exp_s.tree_weight, tree_weight_o);
          report_field("connected", SUM_W'(exp_s.connected), SUM_W'(connected_o));
          report_field("edge_overflow", SUM_W'(exp_s.overflow), SUM_W'(edge_overflow_o));
        end
      end
      if (start && !busy) begin
        if (graph_edge_cnt < MAX_EDGES) begin
          graph_edges[graph_edge_cnt] = '{edge_from_i, edge_to_i, edge_weight_i};
          graph_edge_cnt++;
        end else graph_ovf = 1'b1;
        if (last_edge_i) begin
          span_expect_q.push_back(span_of_graph());
          graph_edge_cnt = 0;
          graph_ovf = 1'b0;
        end
      end
      awaiting_o <= span_expect_q.size();
    end
  end

  initial mismatches = 0;
  always_comb fail_count_o = mismatches + ((awaiting_o < 0) ? 1 : 0);

endmodule

// ----- bench/tb.sv -----
// Testbench top for the Boruvka spanning-tree weight block: stimulus and verdict.
module tb
  import bmst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [1:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic [ID_W-1:0]   edge_from_i;
  logic [ID_W-1:0]   edge_to_i;
  logic [WGT_W-1:0]  edge_weight_i;
  logic              last_edge_i;
  logic              done_o;
  logic [SUM_W-1:0]  tree_weight_o;
  logic              connected_o;
  logic              edge_overflow_o;
  int                fail_count;
  int                awaiting;
  int                sent_edges;
  int unsigned       gap_pct;

  boruvka_mst_weight u_top (.*);

  bmst_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .start, .busy, .edge_from_i, .edge_to_i, .edge_weight_i, .last_edge_i,
    .done_o, .tree_weight_o, .connected_o, .edge_overflow_o,
    .fail_count_o(fail_count), .awaiting_o(awaiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #30ms;
    $display("== FAIL ==");
    $finish;
  end

  // Present one edge beat and hold it until accepted.
  task automatic send_edge(logic [ID_W-1:0] f, logic [ID_W-1:0] t, logic [WGT_W-1:0] w,
                           logic lst);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    edge_from_i <= f;
    edge_to_i <= t;
    edge_weight_i <= w;
    last_edge_i <= lst;
    do @(posedge clk_i); while (busy);
    sent_edges++;
  endtask

  // Drop start and wait until every result is back.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (awaiting != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_nodes(logic [ID_W-1:0] n);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_NODE_COUNT;
    pwdata <= 32'(n);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [WGT_W-1:0] pick_weight(bit tie_heavy);
    if (tie_heavy) return WGT_W'($urandom_range(7));
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Random graph: often a spanning tree first, then extra edges and noise.
  task automatic random_graph();
    int unsigned n;
    int unsigned extra;
    int unsigned a;
    int unsigned b;
    bit ties;
    bit tree_first;
    case ($urandom_range(19))
      0: n = 1;
      1: n = 1024;
      2: n = $urandom_range(13, 64);
      default: n = $urandom_range(2, 12);
    endcase
    write_nodes(ID_W'(n));
    ties = $urandom_range(1);
    tree_first = (n <= 64) && $urandom_range(1);
    extra = $urandom_range(1, 12);
    if (tree_first)
      for (int unsigned v = 2; v <= n; v++)
        send_edge(ID_W'(v), ID_W'($urandom_range(1, v - 1)), pick_weight(ties), 1'b0);
    for (int unsigned k = 0; k < extra; k++) begin
      a = $urandom_range(1, n);
      b = $urandom_range(1, n);
      if ($urandom_range(15) == 0) a = $urandom_range(2047);
      if ($urandom_range(15) == 0) b = 0;
      if ($urandom_range(15) == 0) b = a;
      send_edge(ID_W'(a), ID_W'(b), pick_weight(ties), k == extra - 1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    edge_from_i = '0;
    edge_to_i = '0;
    edge_weight_i = '0;
    last_edge_i = 1'b0;
    sent_edges = 0;
    gap_pct = 14;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset count, single vertex, zero and clamped counts.
    send_edge(11'd1, 11'd1, 32'd5, 1'b1);
    write_nodes(11'd0);
    send_edge(11'd1, 11'd2, '1, 1'b1);
    write_nodes(11'd2);
    send_edge(11'd1, 11'd2, '1, 1'b1);
    write_nodes(11'd4);
    send_edge(11'd1, 11'd2, 32'd3, 1'b0);
    send_edge(11'd3, 11'd3, 32'd0, 1'b0);
    send_edge(11'd0, 11'd4, 32'd1, 1'b1);
    send_edge(11'd1, 11'd2, 32'd2, 1'b0);
    send_edge(11'd2, 11'd3, 32'd2, 1'b0);
    send_edge(11'd3, 11'd4, 32'd2, 1'b0);
    send_edge(11'd4, 11'd1, 32'd2, 1'b0);
    send_edge(11'd5, 11'd1, 32'd0, 1'b1);
    write_nodes(11'd2047);
    send_edge(11'd1024, 11'd1, '1, 1'b0);
    send_edge(11'd2047, 11'd1, 32'd0, 1'b0);
    send_edge(11'd1025, 11'd1024, 32'd0, 1'b1);
    write_nodes(11'd1024);
    send_edge(11'd1, 11'd1024, 32'h8000_0000, 1'b1);
    write_nodes(11'd3);
    send_edge(11'd2, 11'd3, '1, 1'b0);
    send_edge(11'd1, 11'd2, 32'h5555_5555, 1'b0);
    send_edge(11'd1, 11'd3, 32'hAAAA_AAAA, 1'b1);

    // Random graphs through three idling phases.
    while (sent_edges < 1650) begin
      gap_pct = (sent_edges < 550) ? 14 : (sent_edges < 1100) ? 52 : 0;
      random_graph();
    end

    // Overfill the edge store; the dropped last edge still starts the run.
    write_nodes(11'd4);
    for (int k = 0; k < MAX_EDGES + 4; k++)
      send_edge(ID_W'($urandom_range(1, 4)), ID_W'($urandom_range(1, 4)), $urandom(),
                k == MAX_EDGES + 3);

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
